// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/gqu_pkg.sv =====
// ----------------------------------------------------------------------------
// gqu_pkg
// Types, stage map and fixed-point constants of the gyro quaternion update.
// ----------------------------------------------------------------------------
`default_nettype none

package gqu_pkg;

   typedef struct packed {
      logic signed [23:0] cur_w;
      logic signed [23:0] cur_x;
      logic signed [23:0] cur_y;
      logic signed [23:0] cur_z;
      logic [31:0]        cur_stamp;
      logic signed [23:0] rate_roll;
      logic signed [23:0] rate_pitch;
      logic signed [23:0] rate_yaw;
      logic [15:0]        step_time;
   } req_type;

   typedef struct packed {
      logic signed [23:0] new_w;
      logic signed [23:0] new_x;
      logic signed [23:0] new_y;
      logic signed [23:0] new_z;
      logic [31:0]        new_stamp;
   } rsp_type;

   typedef struct packed {
      logic signed [23:0] w;
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      logic [31:0]        stamp;
   } quat_type;

   // register index on the control port (paddr[2])
   typedef enum logic {
      CSR_MIN_ANGLE = 1'b0
   } csr_index_type;

   localparam int CSR_ADDR_W = 3;
   localparam logic [15:0] MIN_ANGLE_RESET = 16'd687;

   localparam int SQRT_STEPS   = 32;
   localparam int CORDIC_STEPS = 30;
   localparam int DIV_STEPS    = 32;

   // stage map: index of the register stage that holds each step
   localparam int ST_SQ       = 0;
   localparam int ST_SUM      = 1;
   localparam int ST_SQRT0    = 2;
   localparam int ST_ANG      = ST_SQRT0 + SQRT_STEPS;
   localparam int ST_MOD      = ST_ANG + 1;
   localparam int ST_FOLD     = ST_MOD + 1;
   localparam int ST_CORD0    = ST_FOLD + 1;
   localparam int ST_ABS      = ST_CORD0 + CORDIC_STEPS;
   localparam int ST_DIV0     = ST_ABS + 1;
   localparam int ST_SGN      = ST_DIV0 + DIV_STEPS;
   localparam int ST_PROD     = ST_SGN + 1;
   localparam int ST_ACC      = ST_PROD + 1;
   localparam int PIPE_DEPTH  = ST_ACC + 1;

   localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
   localparam logic [32:0] PI_Q30      = 33'd3373259426;
   localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
   localparam logic [32:0] FOLD_HI_Q30 = 33'd5059889139;  // 2*pi - pi/2

   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
      30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
      30'd1048575,   30'd524287,    30'd262144,    30'd131072,    30'd65536,
      30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
      30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
      30'd32,        30'd16,        30'd8,         30'd4,         30'd2
   };

   localparam logic signed [29:0] Q22_MAX = 30'sd8388607;
   localparam logic signed [29:0] Q22_MIN = -30'sd8388608;

endpackage

`default_nettype wire

// ===== hw/rtl/gqu_cordic.sv =====
// ----------------------------------------------------------------------------
// gqu_cordic
// Pipelined rotation-mode CORDIC, one iteration per stage, cos/sin in Q30.
// ----------------------------------------------------------------------------
`default_nettype none

module gqu_cordic (
   input  logic               clock,
   input  logic               adv,
   input  logic signed [34:0] ang_in,
   output logic signed [33:0] cos_out,
   output logic signed [33:0] sin_out
);

   localparam int N = gqu_pkg::CORDIC_STEPS;

   logic signed [33:0] x_ff [N];
   logic signed [33:0] y_ff [N];
   logic signed [34:0] t_ff [N-1];

   for (genvar i = 0; i < N; i++) begin : g_it
      logic signed [33:0] x_src, y_src, x_in, y_in;
      logic signed [34:0] t_src;

      if (i == 0) begin : g_first
         assign x_src = gqu_pkg::CORDIC_GAIN_Q30;
         assign y_src = '0;
         assign t_src = ang_in;
      end else begin : g_next
         assign x_src = x_ff[i-1];
         assign y_src = y_ff[i-1];
         assign t_src = t_ff[i-1];
      end

      // rotate toward zero residual angle
      always_comb begin
         if (t_src >= 0) begin
            x_in = x_src - (y_src >>> i);
            y_in = y_src + (x_src >>> i);
         end else begin
            x_in = x_src + (y_src >>> i);
            y_in = y_src - (x_src >>> i);
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
         end
      end

      if (i < N - 1) begin : g_ang
         logic signed [34:0] atan_s, t_in;
         assign atan_s = $signed({5'b0, gqu_pkg::ATAN_Q30[i]});
         assign t_in   = (t_src >= 0) ? (t_src - atan_s) : (t_src + atan_s);
         always_ff @(posedge clock) begin
            if (adv) begin
               t_ff[i] <= t_in;
            end
         end
      end
   end

   assign cos_out = x_ff[N-1];
   assign sin_out = y_ff[N-1];

endmodule

`default_nettype wire

// ===== hw/rtl/gqu_divider.sv =====
// ----------------------------------------------------------------------------
// gqu_divider
// Pipelined restoring divider, one quotient bit per stage. The upper half of
// the numerator must be below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module gqu_divider (
   input  logic        clock,
   input  logic        adv,
   input  logic [63:0] num_in,
   input  logic [31:0] den_in,
   output logic [31:0] quo_out
);

   localparam int N = gqu_pkg::DIV_STEPS;

   logic [31:0] quo_ff [N];
   logic [31:0] rem_ff [N-1];
   logic [31:0] lo_ff  [N-1];
   logic [31:0] den_ff [N-1];

   for (genvar k = 0; k < N; k++) begin : g_st
      logic [31:0] rem_src, lo_src, quo_src, den_src, quo_in;
      logic [32:0] rem_sh, diff;
      logic        ge;

      if (k == 0) begin : g_first
         assign rem_src = num_in[63:32];
         assign lo_src  = num_in[31:0];
         assign quo_src = '0;
         assign den_src = den_in;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign lo_src  = lo_ff[k-1];
         assign quo_src = quo_ff[k-1];
         assign den_src = den_ff[k-1];
      end

      assign rem_sh = {rem_src, lo_src[31]};
      assign diff   = rem_sh - {1'b0, den_src};
      assign ge     = (rem_sh >= {1'b0, den_src});
      assign quo_in = {quo_src[30:0], ge};

      always_ff @(posedge clock) begin
         if (adv) begin
            quo_ff[k] <= quo_in;
         end
      end

      if (k < N - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k] <= ge ? diff[31:0] : rem_sh[31:0];
               lo_ff[k]  <= {lo_src[30:0], 1'b0};
               den_ff[k] <= den_src;
            end
         end
      end
   end

   assign quo_out = quo_ff[N-1];

endmodule

`default_nettype wire

// ===== hw/rtl/gyro_quaternion_update.sv =====
// ----------------------------------------------------------------------------
// gyro_quaternion_update
// Advances an orientation quaternion by one gyro sample, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready/req_payload) carries the current
//   quaternion (Q2.22), its time stamp, the three gyro rates and the time
//   step. Response channel (rsp_valid/rsp_ready/rsp_payload) returns one
//   updated, saturated quaternion per request, in order, with the stamp.
//   The min_angle register (byte address 0 on the APB-style port) sets the
//   rotation angle below which the quaternion passes unchanged; write it only
//   while no request is in flight.
//   Path from request acceptance to rsp_valid: the bit-serial square root
//   (32 stages), the CORDIC (30 stages), the axis divider (32 stages), the
//   remaining arithmetic stages and the output register.
//   Throughput: one request per cycle unless the skid register is full (req_ready low).
//   Reset clears every valid bit and loads min_angle with 687; request data
//   in flight is dropped.
//   When the receiver stalls, the output register holds its response and
//   one more response lands in a skid register; the pipeline then freezes as
//   a whole (req_ready low) until the skid register drains. Nothing is lost
//   or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gyro_quaternion_update (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  gqu_pkg::req_type                    req_payload,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output gqu_pkg::rsp_type                    rsp_payload,
   // control register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [gqu_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam int ST_SQ    = gqu_pkg::ST_SQ;
   localparam int ST_SUM   = gqu_pkg::ST_SUM;
   localparam int ST_ANG   = gqu_pkg::ST_ANG;
   localparam int ST_MOD   = gqu_pkg::ST_MOD;
   localparam int ST_FOLD  = gqu_pkg::ST_FOLD;
   localparam int ST_ABS   = gqu_pkg::ST_ABS;
   localparam int ST_SGN   = gqu_pkg::ST_SGN;
   localparam int ST_PROD  = gqu_pkg::ST_PROD;
   localparam int ST_ACC   = gqu_pkg::ST_ACC;
   localparam int DEPTH    = gqu_pkg::PIPE_DEPTH;
   localparam int NSQ      = gqu_pkg::SQRT_STEPS;

   // ------------------------------------------------------------------
   // Control register
   // ------------------------------------------------------------------
   logic [15:0] min_angle_ff, min_angle_in;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_comb begin
      min_angle_in = min_angle_ff;
      if (csr_wr && (paddr[2] == gqu_pkg::CSR_MIN_ANGLE)) begin
         min_angle_in = pwdata[15:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == gqu_pkg::CSR_MIN_ANGLE) begin
         prdata = {16'b0, min_angle_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_angle_ff <= gqu_pkg::MIN_ANGLE_RESET;
      end else begin
         min_angle_ff <= min_angle_in;
      end
   end

   // ------------------------------------------------------------------
   // Flow control: the whole pipeline advances unless the skid is full
   // ------------------------------------------------------------------
   logic adv;
   logic skid_vld_ff, skid_vld_in;
   logic rsp_vld_ff, rsp_vld_in;
   gqu_pkg::rsp_type skid_data_ff, skid_data_in;
   gqu_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic vld_ff [DEPTH];

   assign adv       = ~skid_vld_ff;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < DEPTH; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Side lines: request fields and flags that ride along with the math
   // ------------------------------------------------------------------
   gqu_pkg::req_type   req_line_ff [ST_SQ:ST_ABS-1];
   gqu_pkg::quat_type  cur_line_ff [ST_ABS:ST_ACC];
   logic [31:0]        mag_line_ff [ST_ANG:ST_ABS];
   logic               byp_line_ff [ST_MOD:ST_ACC];
   logic               neg_line_ff [ST_FOLD:ST_ABS-1];
   logic signed [33:0] dw_line_ff  [ST_ABS:ST_SGN];
   logic [2:0]         nsg_line_ff [ST_ABS:ST_SGN-1];

   // ------------------------------------------------------------------
   // Squares and sum of squares
   // ------------------------------------------------------------------
   logic [47:0] sq_ff [3];
   logic [47:0] sq_in [3];
   logic [47:0] sum_ff, sum_in;

   always_comb begin
      sq_in[0] = 48'(req_payload.rate_roll)  * 48'(req_payload.rate_roll);
      sq_in[1] = 48'(req_payload.rate_pitch) * 48'(req_payload.rate_pitch);
      sq_in[2] = 48'(req_payload.rate_yaw)   * 48'(req_payload.rate_yaw);
      sum_in   = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   // ------------------------------------------------------------------
   // Rate magnitude: floor(sqrt(sum * 2^16)), one root bit per stage
   // ------------------------------------------------------------------
   logic [31:0] sqr_root_ff [NSQ];
   logic [33:0] sqr_rem_ff  [NSQ-1];
   logic [63:0] sqr_rad_ff  [NSQ-1];

   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      logic [33:0] rem_src;
      logic [31:0] root_src, root_in;
      logic [63:0] rad_src;
      logic [35:0] rem_sh, trial, diff;
      logic        ge;

      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = {sum_ff, 16'b0};
      end else begin : g_next
         assign rem_src  = sqr_rem_ff[k-1];
         assign root_src = sqr_root_ff[k-1];
         assign rad_src  = sqr_rad_ff[k-1];
      end

      assign rem_sh  = {rem_src, rad_src[63:62]};
      assign trial   = {2'b0, root_src, 2'b01};
      assign diff    = rem_sh - trial;
      assign ge      = (rem_sh >= trial);
      assign root_in = {root_src[30:0], ge};

      always_ff @(posedge clock) begin
         if (adv) begin
            sqr_root_ff[k] <= root_in;
         end
      end

      if (k < NSQ - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               sqr_rem_ff[k] <= ge ? diff[33:0] : rem_sh[33:0];
               sqr_rad_ff[k] <= {rad_src[61:0], 2'b0};
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Angle, threshold test, half-angle range reduction and fold
   // ------------------------------------------------------------------
   logic [47:0]        ang_ff, ang_in;
   logic [32:0]        half;
   logic [32:0]        tmod_ff, tmod_in;
   logic               byp_in;
   logic signed [34:0] fold_t_ff, fold_t_in;
   logic               fold_neg_in;

   always_comb begin
      ang_in  = 48'(sqr_root_ff[NSQ-1]) * 48'(req_line_ff[ST_ANG-1].step_time);
      half    = ang_ff[47:15];
      tmod_in = (half >= gqu_pkg::TWO_PI_Q30) ? (half - gqu_pkg::TWO_PI_Q30) : half;
      byp_in  = (mag_line_ff[ST_ANG] == 32'd0) ||
                (ang_ff < {24'b0, min_angle_ff, 8'b0});
   end

   // fold into [-pi/2, pi/2]; the two middle quadrants negate cos and sin
   always_comb begin
      if (tmod_ff <= gqu_pkg::HALF_PI_Q30) begin
         fold_t_in   = $signed({2'b0, tmod_ff});
         fold_neg_in = 1'b0;
      end else if (tmod_ff < gqu_pkg::FOLD_HI_Q30) begin
         fold_t_in   = $signed({2'b0, tmod_ff}) - $signed({2'b0, gqu_pkg::PI_Q30});
         fold_neg_in = 1'b1;
      end else begin
         fold_t_in   = $signed({2'b0, tmod_ff}) - $signed({2'b0, gqu_pkg::TWO_PI_Q30});
         fold_neg_in = 1'b0;
      end
   end

   logic signed [33:0] cord_cos, cord_sin;

   gqu_cordic u_cordic (
      .clock   (clock),
      .adv     (adv),
      .ang_in  (fold_t_ff),
      .cos_out (cord_cos),
      .sin_out (cord_sin)
   );

   // ------------------------------------------------------------------
   // Axis numerators: |rate| * 256 * |sin|, sign kept aside
   // ------------------------------------------------------------------
   logic signed [33:0] dw_in, sin_abs;
   logic               sin_neg;
   logic [23:0]        rate_abs [3];
   logic               rate_neg [3];
   logic [63:0]        num_ff [3];
   logic [63:0]        num_in [3];
   logic [2:0]         nsg_in;
   logic [31:0]        quo [3];

   always_comb begin
      dw_in   = neg_line_ff[ST_ABS-1] ? -cord_cos : cord_cos;
      sin_neg = neg_line_ff[ST_ABS-1] ^ cord_sin[33];
      sin_abs = cord_sin[33] ? -cord_sin : cord_sin;
      rate_neg[0] = req_line_ff[ST_ABS-1].rate_roll[23];
      rate_neg[1] = req_line_ff[ST_ABS-1].rate_pitch[23];
      rate_neg[2] = req_line_ff[ST_ABS-1].rate_yaw[23];
      rate_abs[0] = rate_neg[0] ? 24'(-req_line_ff[ST_ABS-1].rate_roll)
                                : req_line_ff[ST_ABS-1].rate_roll;
      rate_abs[1] = rate_neg[1] ? 24'(-req_line_ff[ST_ABS-1].rate_pitch)
                                : req_line_ff[ST_ABS-1].rate_pitch;
      rate_abs[2] = rate_neg[2] ? 24'(-req_line_ff[ST_ABS-1].rate_yaw)
                                : req_line_ff[ST_ABS-1].rate_yaw;
      for (int j = 0; j < 3; j++) begin
         num_in[j] = {(56'(rate_abs[j]) * 56'(sin_abs[31:0])), 8'b0};
         nsg_in[j] = rate_neg[j] ^ sin_neg;
      end
   end

   for (genvar j = 0; j < 3; j++) begin : g_div
      gqu_divider u_div (
         .clock   (clock),
         .adv     (adv),
         .num_in  (num_ff[j]),
         .den_in  (mag_line_ff[ST_ABS]),
         .quo_out (quo[j])
      );
   end

   // ------------------------------------------------------------------
   // Signed delta, Hamilton product terms and sums
   // ------------------------------------------------------------------
   logic signed [32:0] dv_ff [3];
   logic signed [32:0] dv_in [3];
   logic signed [57:0] pw_ff [4];
   logic signed [57:0] pa_ff [4];
   logic signed [57:0] pb_ff [4];
   logic signed [57:0] pc_ff [4];
   logic signed [57:0] pw_in [4];
   logic signed [57:0] pa_in [4];
   logic signed [57:0] pb_in [4];
   logic signed [57:0] pc_in [4];
   logic signed [23:0] cq [4];
   logic signed [59:0] acc_ff [4];
   logic signed [59:0] acc_in [4];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dv_in[j] = nsg_line_ff[ST_SGN-1][j] ? -$signed({1'b0, quo[j]})
                                              : $signed({1'b0, quo[j]});
      end
      cq[0] = cur_line_ff[ST_SGN].w;
      cq[1] = cur_line_ff[ST_SGN].x;
      cq[2] = cur_line_ff[ST_SGN].y;
      cq[3] = cur_line_ff[ST_SGN].z;
      for (int j = 0; j < 4; j++) begin
         pw_in[j] = 58'(dw_line_ff[ST_SGN]) * 58'(cq[j]);
         pa_in[j] = 58'(dv_ff[0]) * 58'(cq[j]);
         pb_in[j] = 58'(dv_ff[1]) * 58'(cq[j]);
         pc_in[j] = 58'(dv_ff[2]) * 58'(cq[j]);
      end
      acc_in[0] = 60'(pw_ff[0]) - 60'(pa_ff[1]) - 60'(pb_ff[2]) - 60'(pc_ff[3]);
      acc_in[1] = 60'(pw_ff[1]) + 60'(pa_ff[0]) + 60'(pb_ff[3]) - 60'(pc_ff[2]);
      acc_in[2] = 60'(pw_ff[2]) - 60'(pa_ff[3]) + 60'(pb_ff[0]) + 60'(pc_ff[1]);
      acc_in[3] = 60'(pw_ff[3]) + 60'(pa_ff[2]) - 60'(pb_ff[1]) + 60'(pc_ff[0]);
   end

   // ------------------------------------------------------------------
   // Pipeline data registers (no reset; valid bits qualify them)
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv) begin
         // request fields
         req_line_ff[ST_SQ] <= req_payload;
         for (int k = ST_SQ + 1; k < ST_ABS; k++) begin
            req_line_ff[k] <= req_line_ff[k-1];
         end
         cur_line_ff[ST_ABS] <= '{w:     req_line_ff[ST_ABS-1].cur_w,
                                  x:     req_line_ff[ST_ABS-1].cur_x,
                                  y:     req_line_ff[ST_ABS-1].cur_y,
                                  z:     req_line_ff[ST_ABS-1].cur_z,
                                  stamp: req_line_ff[ST_ABS-1].cur_stamp};
         for (int k = ST_ABS + 1; k <= ST_ACC; k++) begin
            cur_line_ff[k] <= cur_line_ff[k-1];
         end
         // magnitude and angle
         for (int j = 0; j < 3; j++) begin
            sq_ff[j] <= sq_in[j];
         end
         sum_ff <= sum_in;
         ang_ff <= ang_in;
         mag_line_ff[ST_ANG] <= sqr_root_ff[NSQ-1];
         for (int k = ST_ANG + 1; k <= ST_ABS; k++) begin
            mag_line_ff[k] <= mag_line_ff[k-1];
         end
         tmod_ff <= tmod_in;
         byp_line_ff[ST_MOD] <= byp_in;
         for (int k = ST_MOD + 1; k <= ST_ACC; k++) begin
            byp_line_ff[k] <= byp_line_ff[k-1];
         end
         fold_t_ff <= fold_t_in;
         neg_line_ff[ST_FOLD] <= fold_neg_in;
         for (int k = ST_FOLD + 1; k < ST_ABS; k++) begin
            neg_line_ff[k] <= neg_line_ff[k-1];
         end
         // delta rotation
         for (int j = 0; j < 3; j++) begin
            num_ff[j] <= num_in[j];
            dv_ff[j]  <= dv_in[j];
         end
         dw_line_ff[ST_ABS]  <= dw_in;
         nsg_line_ff[ST_ABS] <= nsg_in;
         for (int k = ST_ABS + 1; k <= ST_SGN; k++) begin
            dw_line_ff[k] <= dw_line_ff[k-1];
         end
         for (int k = ST_ABS + 1; k < ST_SGN; k++) begin
            nsg_line_ff[k] <= nsg_line_ff[k-1];
         end
         // product and sum
         for (int j = 0; j < 4; j++) begin
            pw_ff[j]  <= pw_in[j];
            pa_ff[j]  <= pa_in[j];
            pb_ff[j]  <= pb_in[j];
            pc_ff[j]  <= pc_in[j];
            acc_ff[j] <= acc_in[j];
         end
      end
   end

   // ------------------------------------------------------------------
   // Round to Q2.22, saturate, bypass at zero rate or below threshold
   // ------------------------------------------------------------------
   function automatic logic signed [23:0] round_sat(input logic signed [59:0] acc);
      logic signed [59:0] rnd;
      logic signed [29:0] shf;
      rnd = acc + (60'sd1 <<< 29);
      shf = $signed(rnd[59:30]);
      if (shf > gqu_pkg::Q22_MAX) begin
         return gqu_pkg::Q22_MAX[23:0];
      end else if (shf < gqu_pkg::Q22_MIN) begin
         return gqu_pkg::Q22_MIN[23:0];
      end
      return shf[23:0];
   endfunction

   gqu_pkg::rsp_type tail;

   always_comb begin
      tail.new_stamp = cur_line_ff[ST_ACC].stamp;
      if (byp_line_ff[ST_ACC]) begin
         tail.new_w = cur_line_ff[ST_ACC].w;
         tail.new_x = cur_line_ff[ST_ACC].x;
         tail.new_y = cur_line_ff[ST_ACC].y;
         tail.new_z = cur_line_ff[ST_ACC].z;
      end else begin
         tail.new_w = round_sat(acc_ff[0]);
         tail.new_x = round_sat(acc_ff[1]);
         tail.new_y = round_sat(acc_ff[2]);
         tail.new_z = round_sat(acc_ff[3]);
      end
   end

   // ------------------------------------------------------------------
   // Output register plus skid register
   // ------------------------------------------------------------------
   logic take, push;

   assign take = rsp_vld_ff & rsp_ready;
   assign push = adv & vld_ff[ST_ACC];

   always_comb begin
      rsp_vld_in   = rsp_vld_ff;
      rsp_data_in  = rsp_data_ff;
      skid_vld_in  = skid_vld_ff;
      skid_data_in = skid_data_ff;
      if (skid_vld_ff) begin
         // drain the skid first
         if (take) begin
            rsp_data_in = skid_data_ff;
            skid_vld_in = 1'b0;
         end
      end else if (push) begin
         if (!rsp_vld_ff || take) begin
            rsp_vld_in  = 1'b1;
            rsp_data_in = tail;
         end else begin
            skid_vld_in  = 1'b1;
            skid_data_in = tail;
         end
      end else if (take) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_vld_ff, rsp_vld_ff)
   `ASSERT_NEXT(a_skid_fills, clock, reset, rsp_vld_ff && !rsp_ready && !skid_vld_ff && vld_ff[ST_ACC], skid_vld_ff)
   `ASSERT_NEXT(a_skid_drains, clock, reset, skid_vld_ff && rsp_ready, !skid_vld_ff)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pipelined gyro quaternion update.
// Requests go in on the valid/ready channel. A cycle-free predictor computes
// each updated quaternion, and a monitor checks every response in order
// against the queue of expected quaternions. min_angle is set to its
// extremes and random values via the APB-style port with the pipeline empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // pipeline latency plus margin; use it before register writes and at the end
   localparam int SETTLE_CYCLES = 120;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   gqu_pkg::req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   gqu_pkg::rsp_type rsp_payload;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [gqu_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   gyro_quaternion_update i_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // bench copy of the threshold register
   logic [15:0] min_angle_model = gqu_pkg::MIN_ANGLE_RESET;

   gqu_pkg::rsp_type expected_quats[$];
   int          mismatch_count = 0;
   int          request_count = 0;
   int          response_count = 0;
   int          setting_count = 0;
   bit          idle_enable = 1'b1;
   int          holdoff_cycles = 0;

   // arctangent table, Q30 rad
   localparam longint ATAN_TABLE [30] = '{
      843314856, 497837829, 263043836, 133525158, 67021686,
      33543515,  16775850,  8388437,   4194282,   2097149,
      1048575,   524287,    262144,    131072,    65536,
      32768,     16384,     8192,      4096,      2048,
      1024,      512,       256,       128,       64,
      32,        16,        8,         4,         2
   };

   function automatic logic [23:0] round_sat_q22(longint acc);
      longint v;
      v = (acc + 64'sd536870912) >>> 30;
      if (v > 64'sd8388607) v = 64'sd8388607;
      if (v < -64'sd8388608) v = -64'sd8388608;
      return v[23:0];
   endfunction

   // expected updated quaternion for one request under the current threshold
   function automatic gqu_pkg::rsp_type predict_quat(gqu_pkg::req_type r);
      longint unsigned sq, root, bitv, rate_mag, angle;
      longint cw, cx, cy, cz, rx, ry, rz;
      longint t, x, y, nx, cosv, sinv, dw, dx, dy, dz;
      bit     flip;
      gqu_pkg::rsp_type o;
      cw = r.cur_w;  cx = r.cur_x;  cy = r.cur_y;  cz = r.cur_z;
      rx = r.rate_roll;  ry = r.rate_pitch;  rz = r.rate_yaw;
      o.new_stamp = r.cur_stamp;
      sq = (rx * rx + ry * ry + rz * rz) << 16;
      // integer square root, two bits per pass
      root = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > sq) bitv >>= 2;
      while (bitv != 0) begin
         if (sq >= root + bitv) begin
            sq -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      rate_mag = root;
      angle = rate_mag * r.step_time;
      if (rate_mag == 0 || angle < (longint'(min_angle_model) << 8)) begin
         o.new_w = r.cur_w;  o.new_x = r.cur_x;
         o.new_y = r.cur_y;  o.new_z = r.cur_z;
         return o;
      end
      // reduce half angle to one turn, fold into [-pi/2, pi/2]
      t = longint'((angle >> 15) % 64'd6746518852);
      flip = 1'b0;
      if (t > 64'sd3373259426) t -= 64'sd6746518852;
      if (t > 64'sd1686629713) begin
         t -= 64'sd3373259426;
         flip = 1'b1;
      end else if (t < -64'sd1686629713) begin
         t += 64'sd3373259426;
         flip = 1'b1;
      end
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         if (t >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            t -= ATAN_TABLE[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            t += ATAN_TABLE[i];
         end
         x = nx;
      end
      cosv = flip ? -x : x;
      sinv = flip ? -y : y;
      dw = cosv;
      dx = (rx * 256 * sinv) / longint'(rate_mag);
      dy = (ry * 256 * sinv) / longint'(rate_mag);
      dz = (rz * 256 * sinv) / longint'(rate_mag);
      o.new_w = round_sat_q22(dw * cw - dx * cx - dy * cy - dz * cz);
      o.new_x = round_sat_q22(dw * cx + dx * cw + dy * cz - dz * cy);
      o.new_y = round_sat_q22(dw * cy - dx * cz + dy * cw + dz * cx);
      o.new_z = round_sat_q22(dw * cz + dx * cy - dy * cx + dz * cw);
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Response side: random stall bursts, long hold-off on request.
   // ------------------------------------------------------------------------
   int stall_left = 0;
   always @(posedge clock) begin
      if (holdoff_cycles > 0) begin
         holdoff_cycles <= holdoff_cycles - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 6) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Check each accepted response against the oldest expected quaternion.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         response_count++;
         if (expected_quats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: response with nothing expected: %h", $realtime, rsp_payload);
         end else begin
            gqu_pkg::rsp_type want;
            want = expected_quats.pop_front();
            if (rsp_payload !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: mismatch w %0d/%0d x %0d/%0d y %0d/%0d z %0d/%0d st %h/%h",
                     $realtime, want.new_w, rsp_payload.new_w, want.new_x, rsp_payload.new_x,
                     want.new_y, rsp_payload.new_y, want.new_z, rsp_payload.new_z,
                     want.new_stamp, rsp_payload.new_stamp);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   // Drive one request, optionally after an idle burst; hold until accepted.
   task automatic send_request(gqu_pkg::req_type r);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      expected_quats.push_back(predict_quat(r));
      request_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_quats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write_min_angle(logic [15:0] value);
      gqu_pkg::csr_index_type idx;
      idx = gqu_pkg::CSR_MIN_ANGLE;
      wait_drained();
      psel <= 1'b1;  pwrite <= 1'b1;  penable <= 1'b0;
      paddr <= {idx, 2'b00};  pwdata <= {16'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;  penable <= 1'b0;  pwrite <= 1'b0;
      min_angle_model = value;
      setting_count++;
   endtask

   task automatic csr_check_min_angle();
      gqu_pkg::csr_index_type idx;
      idx = gqu_pkg::CSR_MIN_ANGLE;
      req_valid <= 1'b0;
      psel <= 1'b1;  pwrite <= 1'b0;  penable <= 1'b0;  paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[15:0] !== min_angle_model) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: min_angle read %h, want %h", $realtime, prdata, min_angle_model);
      end
      psel <= 1'b0;  penable <= 1'b0;
   endtask

   function automatic gqu_pkg::req_type make_req(int w, int x, int y, int z, int unsigned st,
                                                 int r, int p, int yw, int stp);
      gqu_pkg::req_type q;
      q.cur_w = 24'(w);  q.cur_x = 24'(x);  q.cur_y = 24'(y);  q.cur_z = 24'(z);
      q.cur_stamp = st;
      q.rate_roll = 24'(r);  q.rate_pitch = 24'(p);  q.rate_yaw = 24'(yw);
      q.step_time = 16'(stp);
      return q;
   endfunction

   // Mostly near-unit quaternions with rates of varied size; some raw noise.
   function automatic gqu_pkg::req_type random_req();
      gqu_pkg::req_type q;
      q = gqu_pkg::req_type'({$urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom});
      if ($urandom_range(0, 3) != 0) begin
         q.cur_w = 24'sd4194304 - $signed(24'($urandom_range(0, 1 << 20)));
         q.cur_x = $signed(q.cur_x) >>> $urandom_range(2, 12);
         q.cur_y = $signed(q.cur_y) >>> $urandom_range(2, 12);
         q.cur_z = $signed(q.cur_z) >>> $urandom_range(2, 12);
         q.rate_roll  = $signed(q.rate_roll)  >>> $urandom_range(0, 20);
         q.rate_pitch = $signed(q.rate_pitch) >>> $urandom_range(0, 20);
         q.rate_yaw   = $signed(q.rate_yaw)   >>> $urandom_range(0, 20);
         if ($urandom_range(0, 1)) q.step_time = q.step_time >> $urandom_range(0, 12);
      end
      return q;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_reset_register();
      csr_check_min_angle();
   endtask

   // Field extremes, zero rate, zero step, non-unit and saturating quaternions.
   task automatic test_directed();
      send_request(make_req(4194304, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(4194304, 0, 0, 0, 32'hFFFF_FFFF, 65536, 0, 0, 1024));
      send_request(make_req(4194304, 0, 0, 0, 1, 0, 65536, 0, 65535));
      send_request(make_req(4194304, 0, 0, 0, 2, 0, 0, -65536, 65535));
      send_request(make_req(8388607, 8388607, 8388607, 8388607, 3,
                            8388607, 8388607, 8388607, 65535));
      send_request(make_req(-8388608, -8388608, -8388608, -8388608, 4,
                            -8388608, -8388608, -8388608, 65535));
      send_request(make_req(-8388608, 8388607, -8388608, 8388607, 5,
                            -8388608, 8388607, 0, 1));
      send_request(make_req(2965821, 2965821, 0, 0, 6, 1, 0, 0, 1));     // under threshold
      send_request(make_req(2965821, 0, 2965821, 0, 7, 300, 400, 0, 0)); // zero step
      send_request(make_req(0, 0, 0, 4194304, 8, 0, 0, 0, 65535));       // zero rate
      send_request(make_req(4194304, 0, 0, 0, 9, 1000, -2000, 3000, 40000));
      csr_write_min_angle(16'h0000);
      send_request(make_req(4194304, 0, 0, 0, 10, 0, 0, 0, 65535));      // zero rate
      send_request(make_req(1000, -1000, 2000, -2000, 11, 0, 0, 1, 0));  // zero step
      send_request(make_req(4194304, 0, 0, 0, 12, 1, 1, 1, 1));
      csr_write_min_angle(16'hFFFF);
      send_request(make_req(4194304, 0, 0, 0, 13, 8388607, 8388607, 8388607, 65535));
      send_request(make_req(4194304, 0, 0, 0, 14, 100, 0, 0, 65535));
      csr_check_min_angle();
   endtask

   task automatic test_random_phase(logic [15:0] threshold, int n);
      csr_write_min_angle(threshold);
      repeat (n) send_request(random_req());
   endtask

   // Hold off responses long enough to fill the pipeline and stall requests.
   task automatic test_backpressure();
      holdoff_cycles = 400;
      repeat (250) send_request(random_req());
   endtask

   // Stop sending until every expected quaternion has come back.
   task automatic test_pause_and_resume();
      repeat (50) send_request(random_req());
      req_valid <= 1'b0;
      while (expected_quats.size() != 0) @(posedge clock);
      repeat (100) send_request(random_req());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_register();
      test_directed();
      test_random_phase(16'd0, 400);
      test_random_phase(16'hFFFF, 300);
      test_random_phase(16'($urandom), 300);
      test_backpressure();
      test_pause_and_resume();
      test_random_phase(gqu_pkg::MIN_ANGLE_RESET, 300);
      // no idling on either side from here on
      idle_enable = 1'b0;
      test_random_phase(16'($urandom_range(0, 2000)), 300);
      wait_drained();
      $display("covered %0d requests, %0d responses, %0d threshold settings",
               request_count, response_count, setting_count);
      $display("including extremes, zero rate/step, saturation and a full stall");
      if (mismatch_count == 0 && expected_quats.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatch_count,
                  expected_quats.size());
         $display("tb: errors");
      end
      $finish;
   end

   // Hard limit on run time.
   initial begin
      #2ms;
      $display("timeout with %0d responses outstanding", expected_quats.size());
      $display("tb: errors");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/gqu_pkg.sv
hw/rtl/gqu_cordic.sv
hw/rtl/gqu_divider.sv
hw/rtl/gyro_quaternion_update.sv
tb/tb.sv
